### rtl/jdcd_pkg.sv
// Shared widths, scaled-integer constants and lookup tables for the day-number-to-date converter.
`default_nettype none

package jdcd_pkg;

  // Pipeline depth shared by the date path, the time path and the valid chain.
  localparam int NumStages = 6;

  // Port widths.
  localparam int DayW   = 23;
  localparam int MsW    = 27;
  localparam int MonthW = 4;
  localparam int DomW   = 5;
  localparam int YearW  = 16;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int MsecW  = 10;

  // Internal widths of the date path.
  localparam int TW      = 25;  // 4*(day - anchor) - 1
  localparam int AlphaW  = 8;   // century correction count
  localparam int BW      = 24;  // shifted day count
  localparam int NcW     = 30;  // 100*b - 12210
  localparam int CW      = 15;  // Julian-style year count
  localparam int XW      = 10;  // day of the March-based year plus offset
  localparam int EW      = 5;   // March-based month index

  // Internal widths of the time path.
  localparam int SecsW = 17;  // whole seconds of the day
  localparam int RemW  = 12;  // seconds within the hour

  localparam logic [DayW-1:0] GregStart  = DayW'(2299161);
  localparam logic [DayW-1:0] GregAnchor = DayW'(1867216);
  localparam logic [MsW-1:0]  MsMax      = MsW'(86399999);

  // Reciprocals for exact floor division: q = (n * ceil(2^S / D)) >> S.
  // Each shift is the numerator width plus ceil(log2(D)), which keeps the
  // rounding error of the reciprocal below one unit of the quotient.
  localparam int AlphaShift = 43;
  localparam int AlphaRw    = 26;
  localparam longint unsigned AlphaDiv = 146097;
  localparam logic [AlphaRw-1:0] AlphaRecip =
    AlphaRw'(((64'd1 << AlphaShift) + AlphaDiv - 1) / AlphaDiv);

  localparam int CShift = 46;
  localparam int CRw    = 31;
  localparam longint unsigned CDiv = 36525;
  localparam logic [CRw-1:0] CRecip = CRw'(((64'd1 << CShift) + CDiv - 1) / CDiv);

  localparam int SecShift = 37;
  localparam int SecRw    = 28;
  localparam longint unsigned SecDiv = 1000;
  localparam logic [SecRw-1:0] SecRecip =
    SecRw'(((64'd1 << SecShift) + SecDiv - 1) / SecDiv);

  localparam int HrShift = 29;
  localparam int HrRw    = 18;
  localparam longint unsigned HrDiv = 3600;
  localparam logic [HrRw-1:0] HrRecip = HrRw'(((64'd1 << HrShift) + HrDiv - 1) / HrDiv);

  localparam int MinShift = 18;
  localparam int MinRw    = 13;
  localparam longint unsigned MinDiv = 60;
  localparam logic [MinRw-1:0] MinRecip =
    MinRw'(((64'd1 << MinShift) + MinDiv - 1) / MinDiv);

  // Smallest x with floor(10000*x / 306001) >= k, for k = 1 .. 16.
  localparam int NumThresh = 16;
  localparam logic [XW-1:0] EThresh [NumThresh] = '{
    10'd31,  10'd62,  10'd92,  10'd123, 10'd154, 10'd184, 10'd215, 10'd245,
    10'd276, 10'd307, 10'd337, 10'd368, 10'd398, 10'd429, 10'd460, 10'd490
  };

  // floor(30.6001 * e) for e = 0 .. 16.
  localparam int NumFloor = 17;
  localparam logic [XW-1:0] EFloor [NumFloor] = '{
    10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
    10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459,
    10'd489
  };

  // Month index from the day offset within the March-based year.
  function automatic logic [EW-1:0] jdcd_e_of(input logic [XW-1:0] x);
    logic [EW-1:0] e;
    e = '0;
    for (int k = 0; k < NumThresh; k++) begin
      if (x >= EThresh[k]) begin
        e = EW'(k + 1);
      end
    end
    return e;
  endfunction

endpackage

`default_nettype wire

### rtl/jdcd_date_pipe.sv
// Six-stage date path: Julian day number to month, day of month and year.
`default_nettype none

module jdcd_date_pipe (
  input  logic                               clk_i,
  input  logic [jdcd_pkg::NumStages-1:0]     en_i,
  input  logic [jdcd_pkg::DayW-1:0]          day_number_i,
  output logic [jdcd_pkg::MonthW-1:0]        month_o,
  output logic [jdcd_pkg::DomW-1:0]          day_of_month_o,
  output logic signed [jdcd_pkg::YearW-1:0]  year_o
);
  import jdcd_pkg::*;

  // Stage 1: Gregorian test and scaled numerator of the century correction.
  logic [DayW-1:0] s1_jdn_q;
  logic            s1_greg_q;
  logic [TW-1:0]   s1_t_q;
  logic            greg_d;
  logic [DayW-1:0] diff_d;
  logic [TW-1:0]   t_d;

  always_comb begin
    greg_d = day_number_i >= GregStart;
    diff_d = day_number_i - GregAnchor;
    t_d    = greg_d ? ({diff_d, 2'b00} - TW'(1)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_jdn_q  <= day_number_i;
      s1_greg_q <= greg_d;
      s1_t_q    <= t_d;
    end
  end

  // Stage 2: alpha = floor(t / 146097) by reciprocal multiply.
  localparam int AProdW = TW + AlphaRw;
  logic [AProdW-1:0] alpha_prod;
  logic [DayW-1:0]   s2_jdn_q;
  logic              s2_greg_q;
  logic [AlphaW-1:0] s2_alpha_q;

  assign alpha_prod = AProdW'(s1_t_q) * AProdW'(AlphaRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_jdn_q   <= s1_jdn_q;
      s2_greg_q  <= s1_greg_q;
      s2_alpha_q <= alpha_prod[AlphaShift +: AlphaW];
    end
  end

  // Stage 3: corrected day count b and the numerator of the year count.
  logic [BW-1:0]  adj_d;
  logic [BW-1:0]  b_d;
  logic [NcW-1:0] nc_d;
  logic [BW-1:0]  s3_b_q;
  logic [NcW-1:0] s3_nc_q;

  always_comb begin
    adj_d = s2_greg_q ? (BW'(s2_alpha_q) + BW'(1) - BW'(s2_alpha_q >> 2)) : '0;
    b_d   = BW'(s2_jdn_q) + adj_d + BW'(1524);
    nc_d  = NcW'(b_d) * NcW'(100) - NcW'(12210);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_b_q  <= b_d;
      s3_nc_q <= nc_d;
    end
  end

  // Stage 4: c = floor(nc / 36525) by reciprocal multiply.
  localparam int CProdW = NcW + CRw;
  logic [CProdW-1:0] c_prod;
  logic [BW-1:0]     s4_b_q;
  logic [CW-1:0]     s4_c_q;

  assign c_prod = CProdW'(s3_nc_q) * CProdW'(CRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_b_q <= s3_b_q;
      s4_c_q <= c_prod[CShift +: CW];
    end
  end

  // Stage 5: day offset within the March-based year and the raw year.
  logic [BW-1:0]    d_d;
  logic [XW-1:0]    x_d;
  logic [YearW-1:0] yr_base_d;
  logic [XW-1:0]    s5_x_q;
  logic [YearW-1:0] s5_yr_q;

  always_comb begin
    d_d       = BW'(s4_c_q) * BW'(365) + BW'(s4_c_q >> 2);
    x_d       = XW'(s4_b_q - d_d);
    yr_base_d = YearW'(s4_c_q) - YearW'(4715);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_x_q  <= x_d;
      s5_yr_q <= yr_base_d;
    end
  end

  // Stage 6: month, day of month and the final year with no year zero.
  logic [EW-1:0]           e_d;
  logic [EW-1:0]           mon_raw;
  logic [MonthW-1:0]       mon_d;
  logic [DomW-1:0]         dom_d;
  logic signed [YearW-1:0] yr1_d;
  logic signed [YearW-1:0] yr_d;

  always_comb begin
    e_d     = jdcd_e_of(s5_x_q);
    mon_raw = e_d - EW'(1);
    if (mon_raw > EW'(12)) begin
      mon_raw = mon_raw - EW'(12);
    end
    mon_d = MonthW'(mon_raw);
    dom_d = DomW'(s5_x_q - EFloor[e_d]);
    yr1_d = $signed(s5_yr_q) - ((mon_raw > EW'(2)) ? YearW'(1) : YearW'(0));
    yr_d  = (yr1_d <= 0) ? (yr1_d - YearW'(1)) : yr1_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      month_o        <= mon_d;
      day_of_month_o <= dom_d;
      year_o         <= yr_d;
    end
  end

endmodule

`default_nettype wire

### rtl/jdcd_time_pipe.sv
// Six-stage time path: milliseconds of the day to hour, minute, second and millisecond.
`default_nettype none

module jdcd_time_pipe (
  input  logic                           clk_i,
  input  logic [jdcd_pkg::NumStages-1:0] en_i,
  input  logic [jdcd_pkg::MsW-1:0]       ms_of_day_i,
  output logic [jdcd_pkg::HourW-1:0]     hour_o,
  output logic [jdcd_pkg::MinW-1:0]      minute_o,
  output logic [jdcd_pkg::SecW-1:0]      second_o,
  output logic [jdcd_pkg::MsecW-1:0]     millisecond_o
);
  import jdcd_pkg::*;

  // Stage 1: clamp to the last millisecond of the day.
  logic [MsW-1:0] s1_ms_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_ms_q <= (ms_of_day_i > MsMax) ? MsMax : ms_of_day_i;
    end
  end

  // Stage 2: whole seconds by reciprocal multiply.
  localparam int SProdW = MsW + SecRw;
  logic [SProdW-1:0] secs_prod;
  logic [MsW-1:0]    s2_ms_q;
  logic [SecsW-1:0]  s2_secs_q;

  assign secs_prod = SProdW'(s1_ms_q) * SProdW'(SecRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_ms_q   <= s1_ms_q;
      s2_secs_q <= secs_prod[SecShift +: SecsW];
    end
  end

  // Stage 3: millisecond remainder and hour by reciprocal multiply.
  localparam int HProdW = SecsW + HrRw;
  logic [HProdW-1:0] hr_prod;
  logic [MsecW-1:0]  msr_d;
  logic [SecsW-1:0]  s3_secs_q;
  logic [HourW-1:0]  s3_hr_q;
  logic [MsecW-1:0]  s3_msr_q;

  always_comb begin
    hr_prod = HProdW'(s2_secs_q) * HProdW'(HrRecip);
    msr_d   = MsecW'(s2_ms_q - MsW'(s2_secs_q) * MsW'(1000));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_secs_q <= s2_secs_q;
      s3_hr_q   <= hr_prod[HrShift +: HourW];
      s3_msr_q  <= msr_d;
    end
  end

  // Stage 4: seconds within the hour.
  logic [RemW-1:0]  s4_rem_q;
  logic [HourW-1:0] s4_hr_q;
  logic [MsecW-1:0] s4_msr_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_rem_q <= RemW'(s3_secs_q - SecsW'(s3_hr_q) * SecsW'(3600));
      s4_hr_q  <= s3_hr_q;
      s4_msr_q <= s3_msr_q;
    end
  end

  // Stage 5: minute by reciprocal multiply.
  localparam int MProdW = RemW + MinRw;
  logic [MProdW-1:0] min_prod;
  logic [RemW-1:0]   s5_rem_q;
  logic [MinW-1:0]   s5_min_q;
  logic [HourW-1:0]  s5_hr_q;
  logic [MsecW-1:0]  s5_msr_q;

  assign min_prod = MProdW'(s4_rem_q) * MProdW'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_rem_q <= s4_rem_q;
      s5_min_q <= min_prod[MinShift +: MinW];
      s5_hr_q  <= s4_hr_q;
      s5_msr_q <= s4_msr_q;
    end
  end

  // Stage 6: second remainder and output register.
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      hour_o        <= s5_hr_q;
      minute_o      <= s5_min_q;
      second_o      <= SecW'(s5_rem_q - RemW'(s5_min_q) * RemW'(60));
      millisecond_o <= s5_msr_q;
    end
  end

endmodule

`default_nettype wire

### rtl/julian_day_to_calendar_date_core.sv
// Throughput: one word per cycle unless the output stalls.
// The date and time paths are six-stage pipelines.
// A stalled output holds its word; empty stages fill while the output waits.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits; data registers
// are not reset.
`default_nettype none

module julian_day_to_calendar_date_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [jdcd_pkg::DayW-1:0]         day_number_i,
  input  logic [jdcd_pkg::MsW-1:0]          ms_of_day_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [jdcd_pkg::MonthW-1:0]       month_o,
  output logic [jdcd_pkg::DomW-1:0]         day_of_month_o,
  output logic signed [jdcd_pkg::YearW-1:0] year_o,
  output logic [jdcd_pkg::HourW-1:0]        hour_o,
  output logic [jdcd_pkg::MinW-1:0]         minute_o,
  output logic [jdcd_pkg::SecW-1:0]         second_o,
  output logic [jdcd_pkg::MsecW-1:0]        millisecond_o
);
  import jdcd_pkg::*;

  // One valid bit per stage. A stage may load when it is empty or when the
  // stage after it moves on in the same cycle, so bubbles collapse and a
  // word in flight is never dropped or duplicated during a stall.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] stage_en;
  logic [NumStages:0]   ready_chain;
  logic [NumStages:0]   valid_chain;

  always_comb begin
    ready_chain[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready_chain[k] = !valid_q[k] || ready_chain[k + 1];
    end
    valid_chain = {valid_q, in_valid_i};
    for (int k = 0; k < NumStages; k++) begin
      stage_en[k] = ready_chain[k];
      valid_d[k]  = stage_en[k] ? valid_chain[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready_chain[0];
  assign out_valid_o = valid_q[NumStages - 1];

  // The date and time paths share the stage enables, so both halves of a
  // result word reach the output register in the same cycle.
  jdcd_date_pipe u_date (
    .clk_i          (clk_i),
    .en_i           (stage_en),
    .day_number_i   (day_number_i),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .year_o         (year_o)
  );

  jdcd_time_pipe u_time (
    .clk_i         (clk_i),
    .en_i          (stage_en),
    .ms_of_day_i   (ms_of_day_i),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o),
    .millisecond_o (millisecond_o)
  );

  // An empty output stage means every earlier stage can advance.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output stage is empty");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 &&
                     day_of_month_o >= 5'd1 && year_o != 16'sd0))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 &&
                     second_o <= 6'd59 && millisecond_o <= 10'd999))
    else $error("time field out of range");

endmodule

`default_nettype wire
